// ===== rtl/core/telemetry_bus_poll_master_top_macros.svh =====
// assertion helpers for the telemetry poll master
`ifndef TELEMETRY_BUS_POLL_MASTER_TOP_MACROS_SVH
`define TELEMETRY_BUS_POLL_MASTER_TOP_MACROS_SVH

// same-cycle implication on the rising edge of clk
`define TBPM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication on the rising edge of clk
`define TBPM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/tbpm_pkg.sv =====
`default_nettype none
package tbpm_pkg;

	localparam int SENSOR_IDS_DEF = 28;
	localparam int ID_W           = 5;
	localparam int MASK_W         = 28;
	localparam int FRAME_DATA     = 7;   // frame bytes 2..8
	localparam int FB_IDX_W       = 3;
	localparam int CNT_W          = 4;

	localparam logic [CNT_W-1:0] FIRST_DATA = CNT_W'(2);
	localparam logic [CNT_W-1:0] LAST_DATA  = CNT_W'(8);
	localparam logic [CNT_W-1:0] CHK_IDX    = CNT_W'(9);

	localparam logic [7:0] FRAME_START = 8'h7E;
	localparam logic [7:0] STUFF_MARK  = 8'h7D;
	localparam logic [7:0] STUFF_XOR   = 8'h20;
	localparam logic [7:0] CHK_BASE    = 8'hFF;

	typedef enum logic {
		OP_POLL = 1'b0,
		OP_BYTE = 1'b1
	} op_t;

	typedef enum logic {
		KIND_TX    = 1'b0,
		KIND_FRAME = 1'b1
	} kind_t;

	typedef struct packed {
		logic          kind;
		logic [7:0]    tx_byte;
		logic [ID_W-1:0] sensor_id;
		logic [7:0]    frame_kind;
		logic [15:0]   value_id;
		logic [31:0]   sensor_value;
		logic [MASK_W-1:0] active_mask;
		logic          last;
	} result_t;

	typedef struct packed {
		logic clear;
		logic byte_vld;
	} rx_ctrl_t;

	typedef struct packed {
		logic done;
		logic good;
	} rx_status_t;

	typedef struct packed {
		logic [ID_W-1:0] id;
		logic            scan_active;
		logic [ID_W-1:0] next_active;
		logic [ID_W-1:0] next_inactive;
	} sel_t;

	function automatic logic [7:0] with_check_bits(input logic [ID_W-1:0] id);
		logic [7:0] v;
		v      = {3'b000, id};
		v[5]   = id[0] ^ id[1] ^ id[2];
		v[6]   = id[2] ^ id[3] ^ id[4];
		v[7]   = id[0] ^ id[2] ^ id[4];
		return v;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/tbpm_if.sv =====
`default_nettype none
interface tbpm_in_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] rx_byte;

	modport source (output valid, output opcode, output rx_byte, input ready);
	modport sink (input valid, input opcode, input rx_byte, output ready);
endinterface

interface tbpm_out_if;
	logic                        valid;
	logic                        ready;
	logic                        kind;
	logic [7:0]                  tx_byte;
	logic [tbpm_pkg::ID_W-1:0]   sensor_id;
	logic [7:0]                  frame_kind;
	logic [15:0]                 value_id;
	logic [31:0]                 sensor_value;
	logic [tbpm_pkg::MASK_W-1:0] active_mask;
	logic                        last;

	modport source (output valid, output kind, output tx_byte, output sensor_id,
		output frame_kind, output value_id, output sensor_value, output active_mask,
		output last, input ready);
	modport sink (input valid, input kind, input tx_byte, input sensor_id,
		input frame_kind, input value_id, input sensor_value, input active_mask,
		input last, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/telemetry_bus_poll_master_top.sv =====
// Telemetry bus poll master. Each item on the item channel is either a poll slot
// (opcode 0) or a raw line byte (opcode 1). A poll drops the previously polled
// sensor from the active set if it never answered, picks the next ID by alternating
// active and inactive round-robin scans, and produces two transmit results: 0x7E and
// the ID byte with its three check bits. Line bytes are un-stuffed and gathered into
// a 10-byte frame; a frame with a good checksum marks the sensor active and yields
// one frame result. Every item passes from an input register to a two-entry result
// register; a new item can enter every cycle while the result register has room.
// A poll fills both result entries and the item behind it waits until the result
// side has taken at least one of them.
`default_nettype none
module telemetry_bus_poll_master_top #(
	parameter int SENSOR_IDS = tbpm_pkg::SENSOR_IDS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	tbpm_in_if.sink    item,
	tbpm_out_if.source result
);
	import tbpm_pkg::*;

	logic                  valid_s1;
	logic                  opcode_s1;
	logic [7:0]            byte_s1;

	logic [SENSOR_IDS-1:0] active_q;
	logic                  outstanding_q;
	logic [ID_W-1:0]       polled_id_q;
	logic                  scan_q;
	logic [ID_W-1:0]       next_act_q;
	logic [ID_W-1:0]       next_inact_q;

	logic                  room;
	logic                  proc;
	logic                  is_poll;
	logic [SENSOR_IDS-1:0] polled_bit;
	logic [SENSOR_IDS-1:0] active_clr;
	logic [SENSOR_IDS-1:0] active_set;
	logic [MASK_W-1:0]     mask_clr;
	logic [MASK_W-1:0]     mask_set;
	sel_t                  sel;
	rx_ctrl_t              rx_ctrl;
	rx_status_t            rx_st;
	logic [7:0]            frame_kind;
	logic [15:0]           value_id;
	logic [31:0]           sensor_value;
	result_t               res0;
	result_t               res1;
	logic [1:0]            load_cnt;

	assign proc       = valid_s1 && room;
	assign item.ready = !valid_s1 || proc;
	assign is_poll    = (opcode_s1 == OP_POLL);

	always_comb begin
		polled_bit = {{(SENSOR_IDS-1){1'b0}}, 1'b1} << polled_id_q;
		active_clr = outstanding_q ? (active_q & ~polled_bit) : active_q;
		active_set = active_q | polled_bit;
		mask_clr   = '0;
		mask_set   = '0;
		for (int i = 0; i < MASK_W; i++) begin
			if (i < SENSOR_IDS) begin
				mask_clr[i] = active_clr[i];
				mask_set[i] = active_set[i];
			end
		end
	end

	tbpm_sel #(
		.SENSOR_IDS(SENSOR_IDS)
	) u_sel (
		.active        (active_clr),
		.scan_active   (scan_q),
		.next_active   (next_act_q),
		.next_inactive (next_inact_q),
		.sel           (sel)
	);

	always_comb begin
		rx_ctrl.clear    = proc && is_poll;
		rx_ctrl.byte_vld = proc && !is_poll && outstanding_q;
	end

	tbpm_rx u_rx (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (rx_ctrl),
		.rx_byte      (byte_s1),
		.status       (rx_st),
		.frame_kind   (frame_kind),
		.value_id     (value_id),
		.sensor_value (sensor_value)
	);

	always_comb begin
		res0 = '0;
		res1 = '0;
		if (is_poll) begin
			res0.kind        = KIND_TX;
			res0.tx_byte     = FRAME_START;
			res0.active_mask = mask_clr;
			res0.last        = 1'b0;
			res1.kind        = KIND_TX;
			res1.tx_byte     = with_check_bits(sel.id);
			res1.active_mask = mask_clr;
			res1.last        = 1'b1;
			load_cnt         = 2'd2;
		end else begin
			res0.kind         = KIND_FRAME;
			res0.sensor_id    = polled_id_q;
			res0.frame_kind   = frame_kind;
			res0.value_id     = value_id;
			res0.sensor_value = sensor_value;
			res0.active_mask  = mask_set;
			res0.last         = 1'b1;
			load_cnt          = rx_st.good ? 2'd1 : 2'd0;
		end
	end

	tbpm_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (proc),
		.load_cnt (load_cnt),
		.res0     (res0),
		.res1     (res1),
		.room     (room),
		.result   (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			opcode_s1 <= item.opcode;
			byte_s1   <= item.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q      <= '0;
			outstanding_q <= 1'b0;
			polled_id_q   <= '0;
			scan_q        <= 1'b0;
			next_act_q    <= '0;
			next_inact_q  <= '0;
		end else if (proc && is_poll) begin
			active_q      <= active_clr;
			outstanding_q <= 1'b1;
			polled_id_q   <= sel.id;
			scan_q        <= sel.scan_active;
			next_act_q    <= sel.next_active;
			next_inact_q  <= sel.next_inactive;
		end else if (rx_st.done) begin
			// good or bad, a finished frame ends the wait for this poll
			outstanding_q <= 1'b0;
			if (rx_st.good) begin
				active_q <= active_set;
			end
		end
	end

`include "telemetry_bus_poll_master_top_macros.svh"

	`TBPM_ASSERT_NEXT(a_poll_opens_wait, proc && is_poll, outstanding_q && (32'(polled_id_q) < SENSOR_IDS), "poll did not open a wait on a valid id")
	`TBPM_ASSERT_NEXT(a_frame_ends_wait, rx_st.done, !outstanding_q, "finished frame left the poll open")
	`TBPM_ASSERT_NOW(a_frame_only_when_waiting, rx_st.done, proc && outstanding_q && !is_poll, "frame finished without an open poll")
	`TBPM_ASSERT_NEXT(a_poll_start_byte, proc && is_poll, result.valid && (result.kind == KIND_TX) && (result.tx_byte == FRAME_START) && !result.last, "poll did not lead with the start byte")

endmodule
`default_nettype wire

// ===== rtl/core/tbpm_sel.sv =====
`default_nettype none
module tbpm_sel #(
	parameter int SENSOR_IDS = tbpm_pkg::SENSOR_IDS_DEF
) (
	input  wire logic [SENSOR_IDS-1:0]     active,
	input  wire logic                      scan_active,
	input  wire logic [tbpm_pkg::ID_W-1:0] next_active,
	input  wire logic [tbpm_pkg::ID_W-1:0] next_inactive,
	output tbpm_pkg::sel_t                 sel
);
	import tbpm_pkg::*;

	localparam logic [ID_W-1:0] MAX_ID = ID_W'(SENSOR_IDS - 1);

	logic            all_act;
	logic            none_act;
	logic            scan_eff;
	logic            act_hit;
	logic [ID_W-1:0] act_id;
	logic            hi_hit;
	logic [ID_W-1:0] hi_id;
	logic            lo_hit;
	logic [ID_W-1:0] lo_id;
	logic [ID_W-1:0] inact_id;

	// find-first encoders, lowest index wins
	always_comb begin
		act_hit = 1'b0;
		act_id  = '0;
		hi_hit  = 1'b0;
		hi_id   = '0;
		lo_hit  = 1'b0;
		lo_id   = '0;
		for (int i = SENSOR_IDS - 1; i >= 0; i--) begin
			if (active[i] && ID_W'(i) >= next_active) begin
				act_hit = 1'b1;
				act_id  = ID_W'(i);
			end
			if (!active[i] && ID_W'(i) >= next_inactive) begin
				hi_hit = 1'b1;
				hi_id  = ID_W'(i);
			end
			if (!active[i]) begin
				lo_hit = 1'b1;
				lo_id  = ID_W'(i);
			end
		end
	end

	always_comb begin
		all_act  = &active;
		none_act = ~|active;
		scan_eff = none_act ? 1'b0 : (all_act ? 1'b1 : scan_active);
		// wrap around to the bottom; nothing inactive falls back to id 0
		inact_id = hi_hit ? hi_id : (lo_hit ? lo_id : '0);

		sel.id            = inact_id;
		sel.scan_active   = !none_act;
		sel.next_active   = next_active;
		sel.next_inactive = (inact_id == MAX_ID) ? '0 : inact_id + 1'b1;

		if (scan_eff && act_hit) begin
			sel.id            = act_id;
			sel.next_inactive = next_inactive;
			if (act_id == MAX_ID) begin
				sel.next_active = '0;
				sel.scan_active = all_act;
			end else begin
				sel.next_active = act_id + 1'b1;
				sel.scan_active = 1'b1;
			end
		end else if (scan_eff) begin
			sel.next_active = '0;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/tbpm_rx.sv =====
`default_nettype none
module tbpm_rx (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire tbpm_pkg::rx_ctrl_t ctrl,
	input  wire logic [7:0]     rx_byte,
	output tbpm_pkg::rx_status_t status,
	output logic [7:0]          frame_kind,
	output logic [15:0]         value_id,
	output logic [31:0]         sensor_value
);
	import tbpm_pkg::*;

	logic [CNT_W-1:0]    count_q;
	logic                unstuff_q;
	logic [7:0]          sum_q;
	logic [7:0]          fb_q [FRAME_DATA];

	logic [7:0]          c_eff;
	logic                is_marker;
	logic                store;
	logic                in_data;
	logic [FB_IDX_W-1:0] fb_idx;
	logic [7:0]          sum_base;
	logic [8:0]          sum_raw;
	logic [7:0]          sum_next;

	always_comb begin
		c_eff     = unstuff_q ? (rx_byte ^ STUFF_XOR) : rx_byte;
		is_marker = !unstuff_q && (rx_byte == STUFF_MARK);
		store     = ctrl.byte_vld && !is_marker;
		in_data   = (count_q >= FIRST_DATA) && (count_q <= LAST_DATA);
		fb_idx    = FB_IDX_W'(count_q - FIRST_DATA);
		// end-around-carry checksum kept as the bytes come in
		sum_base  = (count_q == FIRST_DATA) ? 8'h00 : sum_q;
		sum_raw   = {1'b0, sum_base} + {1'b0, c_eff};
		sum_next  = sum_raw[7:0] + {7'b0, sum_raw[8]};

		status.done = store && (count_q == CHK_IDX);
		status.good = status.done && (c_eff == (CHK_BASE - sum_q));

		frame_kind   = fb_q[0];
		value_id     = {fb_q[2], fb_q[1]};
		sensor_value = {fb_q[6], fb_q[5], fb_q[4], fb_q[3]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			unstuff_q <= 1'b0;
		end else if (ctrl.clear) begin
			count_q   <= '0;
			unstuff_q <= 1'b0;
		end else if (ctrl.byte_vld) begin
			unstuff_q <= is_marker;
			if (store) begin
				count_q <= status.done ? '0 : count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (store && in_data) begin
			fb_q[fb_idx] <= c_eff;
			sum_q        <= sum_next;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/tbpm_obuf.sv =====
`default_nettype none
module tbpm_obuf (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        load,
	input  wire logic [1:0]  load_cnt,
	input  wire tbpm_pkg::result_t res0,
	input  wire tbpm_pkg::result_t res1,
	output logic             room,
	tbpm_out_if.source       result
);
	import tbpm_pkg::*;

	logic [1:0] count_q;
	result_t    ent0_q;
	result_t    ent1_q;
	logic       pop;

	always_comb begin
		pop                 = result.valid && result.ready;
		// buffer is empty at the next edge
		room                = (count_q == 2'd0) || ((count_q == 2'd1) && result.ready);
		result.valid        = (count_q != 2'd0);
		result.kind         = ent0_q.kind;
		result.tx_byte      = ent0_q.tx_byte;
		result.sensor_id    = ent0_q.sensor_id;
		result.frame_kind   = ent0_q.frame_kind;
		result.value_id     = ent0_q.value_id;
		result.sensor_value = ent0_q.sensor_value;
		result.active_mask  = ent0_q.active_mask;
		result.last         = ent0_q.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else if (load) begin
			count_q <= load_cnt;
		end else if (pop) begin
			count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ent0_q <= res0;
			ent1_q <= res1;
		end else if (pop) begin
			ent0_q <= ent1_q;
		end
	end

endmodule
`default_nettype wire

// ===== dv/tb_telemetry_bus_poll_master_top.sv =====
`default_nettype none
module tb_telemetry_bus_poll_master_top;
	import tbpm_pkg::*;

	localparam int N_IDS = SENSOR_IDS_DEF;
	localparam logic [MASK_W-1:0] ALL_IDS = {MASK_W{1'b1}};
	localparam int FRAME_BYTES = 10;

	logic clk = 1'b0;
	logic arst_n;

	tbpm_in_if item ();
	tbpm_out_if result ();

	telemetry_bus_poll_master_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item(item.sink),
		.result(result.source)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// bus master state as the testbench tracks it
	logic [MASK_W-1:0] active_bits;
	logic              poll_pending;
	logic [ID_W-1:0]   polled_id;
	logic              scan_active;
	logic [ID_W-1:0]   active_start;
	logic [ID_W-1:0]   inactive_start;
	logic [CNT_W-1:0]  frame_count;
	logic              escape_pending;
	logic [7:0]        frame_buf [FRAME_BYTES];

	result_t tx_and_frame_due [$];
	int send_idle_pct;
	int recv_idle_pct;
	int items_sent;
	int mismatch_count;

	function automatic logic [7:0] id_with_parity(input logic [ID_W-1:0] id);
		return {id[0] ^ id[2] ^ id[4], id[2] ^ id[3] ^ id[4], id[0] ^ id[1] ^ id[2], id};
	endfunction

	function automatic logic [7:0] frame_checksum(input logic [7:0] fb [FRAME_BYTES]);
		int sum;
		sum = 0;
		for (int i = 2; i < 9; i++) begin
			sum = sum + fb[i];
			sum = (sum + (sum >> 8)) & 8'hFF;
		end
		return CHK_BASE - 8'(sum);
	endfunction

	// alternate between the active round-robin and the circular inactive scan
	function automatic logic [ID_W-1:0] next_poll_id();
		int id;
		if (active_bits == '0)
			scan_active = 1'b0;
		else if (active_bits == ALL_IDS)
			scan_active = 1'b1;
		if (scan_active) begin
			id = N_IDS;
			for (int i = active_start; i < N_IDS; i++) begin
				if (active_bits[i] && id == N_IDS)
					id = i;
			end
			if (id < N_IDS) begin
				if (id == N_IDS - 1) begin
					active_start = '0;
					if (active_bits != ALL_IDS)
						scan_active = 1'b0;
				end else begin
					active_start = ID_W'(id + 1);
				end
				return ID_W'(id);
			end
			active_start = '0;
			scan_active = 1'b0;
		end
		id = N_IDS;
		for (int k = 0; k < N_IDS; k++) begin
			if (id == N_IDS && !active_bits[(inactive_start + k) % N_IDS])
				id = (inactive_start + k) % N_IDS;
		end
		if (id >= N_IDS)
			id = 0;
		inactive_start = (id == N_IDS - 1) ? '0 : ID_W'(id + 1);
		if (active_bits != '0)
			scan_active = 1'b1;
		return ID_W'(id);
	endfunction

	task automatic track_poll_and_frame(input op_t op, input logic [7:0] b);
		result_t r;
		logic [7:0] c;
		r = '0;
		c = b;
		if (op == OP_POLL) begin
			if (poll_pending)
				active_bits[polled_id] = 1'b0;
			polled_id = next_poll_id();
			poll_pending = 1'b1;
			frame_count = '0;
			escape_pending = 1'b0;
			r.kind = KIND_TX;
			r.tx_byte = FRAME_START;
			r.active_mask = active_bits;
			tx_and_frame_due.push_back(r);
			r.tx_byte = id_with_parity(polled_id);
			r.last = 1'b1;
			tx_and_frame_due.push_back(r);
			items_sent++;
			return;
		end
		// line byte with no poll outstanding is dropped
		if (!poll_pending)
			return;
		items_sent++;
		if (escape_pending) begin
			c = c ^ STUFF_XOR;
			escape_pending = 1'b0;
		end else if (c == STUFF_MARK) begin
			escape_pending = 1'b1;
			return;
		end
		if (frame_count >= CNT_W'(FRAME_BYTES))
			frame_count = '0;
		frame_buf[frame_count] = c;
		frame_count++;
		if (frame_count < CNT_W'(FRAME_BYTES))
			return;
		poll_pending = 1'b0;
		frame_count = '0;
		if (frame_buf[9] != frame_checksum(frame_buf))
			return;
		active_bits[polled_id] = 1'b1;
		r.kind = KIND_FRAME;
		r.sensor_id = polled_id;
		r.frame_kind = frame_buf[2];
		r.value_id = {frame_buf[4], frame_buf[3]};
		r.sensor_value = {frame_buf[8], frame_buf[7], frame_buf[6], frame_buf[5]};
		r.active_mask = active_bits;
		r.last = 1'b1;
		tx_and_frame_due.push_back(r);
	endtask

	task automatic send_item(input op_t op, input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			item.valid <= 1'b0;
		end
		@(negedge clk);
		item.valid <= 1'b1;
		item.opcode <= op;
		item.rx_byte <= b;
		do @(posedge clk); while (!item.ready);
		track_poll_and_frame(op, b);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		item.valid <= 1'b0;
		while (tx_and_frame_due.size() != 0)
			@(posedge clk);
	endtask

	// escape markers, start bytes and the escaped form of the marker always go stuffed
	task automatic send_line_byte(input logic [7:0] b);
		if (b == STUFF_MARK || b == FRAME_START || b == (STUFF_MARK ^ STUFF_XOR)
				|| $urandom_range(99) < 5) begin
			send_item(OP_BYTE, STUFF_MARK);
			send_item(OP_BYTE, b ^ STUFF_XOR);
		end else begin
			send_item(OP_BYTE, b);
		end
	endtask

	task automatic send_frame(input int count, input bit corrupt, input logic [7:0] fkind,
			input logic [15:0] vid, input logic [31:0] val);
		logic [7:0] fb [FRAME_BYTES];
		fb[0] = FRAME_START;
		fb[1] = ($urandom_range(9) == 0) ? 8'($urandom) : id_with_parity(polled_id);
		fb[2] = fkind;
		{fb[4], fb[3]} = vid;
		{fb[8], fb[7], fb[6], fb[5]} = val;
		fb[9] = frame_checksum(fb);
		if (corrupt)
			fb[9] = fb[9] ^ 8'($urandom_range(1, 255));
		send_item(OP_BYTE, fb[0]);
		for (int i = 1; i < count; i++)
			send_line_byte(fb[i]);
	endtask

	task automatic poll_round(input logic [MASK_W-1:0] present);
		int r;
		send_item(OP_POLL, 8'($urandom));
		r = $urandom_range(99);
		if (present[polled_id]) begin
			if (r < 80)
				send_frame(FRAME_BYTES, 1'b0, 8'($urandom), 16'($urandom), $urandom);
			else if (r < 88)
				send_frame(FRAME_BYTES, 1'b1, 8'($urandom), 16'($urandom), $urandom);
			else if (r < 95)
				send_frame($urandom_range(1, 9), 1'b0, 8'($urandom), 16'($urandom),
					$urandom);
		end else if (r < 15) begin
			repeat ($urandom_range(1, 4))
				send_item(OP_BYTE, 8'($urandom));
		end
		// stray byte between polls
		if ($urandom_range(99) < 5)
			send_item(OP_BYTE, 8'($urandom));
		if ($urandom_range(99) < 3)
			wait_drained();
	endtask

	task automatic test_idle_line();
		send_item(OP_BYTE, 8'hFF);
		send_item(OP_BYTE, 8'h00);
	endtask

	task automatic test_stuffed_frame();
		send_item(OP_POLL, 8'hFF);
		send_frame(FRAME_BYTES, 1'b0, STUFF_MARK, 16'h5DFF, 32'h007E_FF00);
	endtask

	task automatic test_partial_and_bad_frame();
		send_item(OP_POLL, 8'h00);
		send_item(OP_BYTE, FRAME_START);
		send_item(OP_BYTE, STUFF_MARK);
		send_item(OP_POLL, 8'h5A);
		send_frame(FRAME_BYTES, 1'b1, 8'hFF, 16'h0000, 32'hFFFF_FFFF);
		wait_drained();
	endtask

	task automatic test_mixed_traffic(input int n_items);
		logic [MASK_W-1:0] present;
		int stop_at;
		present = MASK_W'($urandom) | MASK_W'($urandom);
		stop_at = items_sent + n_items;
		while (items_sent < stop_at)
			poll_round(present);
		wait_drained();
	endtask

	// answer every poll until all sensors are active, then drop one out again
	task automatic test_full_roster();
		while (active_bits != ALL_IDS) begin
			send_item(OP_POLL, 8'($urandom));
			send_frame(FRAME_BYTES, 1'b0, 8'($urandom), 16'($urandom), $urandom);
		end
		repeat (4)
			poll_round(ALL_IDS);
		send_item(OP_POLL, 8'($urandom));
		repeat (4)
			poll_round(ALL_IDS);
		wait_drained();
	endtask

	task automatic note_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (mismatch_count < 10)
			$display("%0t: %s mismatch: expected %0h, got %0h", $realtime, what, want, got);
		mismatch_count++;
	endtask

	always @(negedge clk) begin
		if (arst_n)
			result.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin : check_results
		result_t got;
		result_t want;
		if (arst_n && result.valid && result.ready) begin
			got = {result.kind, result.tx_byte, result.sensor_id, result.frame_kind,
				result.value_id, result.sensor_value, result.active_mask, result.last};
			if (tx_and_frame_due.size() == 0) begin
				note_mismatch("unexpected transfer, kind", '0, got.kind);
			end else begin
				want = tx_and_frame_due.pop_front();
				if (got.kind != want.kind)
					note_mismatch("kind", want.kind, got.kind);
				if (got.tx_byte != want.tx_byte)
					note_mismatch("tx_byte", want.tx_byte, got.tx_byte);
				if (got.sensor_id != want.sensor_id)
					note_mismatch("sensor_id", want.sensor_id, got.sensor_id);
				if (got.frame_kind != want.frame_kind)
					note_mismatch("frame_kind", want.frame_kind, got.frame_kind);
				if (got.value_id != want.value_id)
					note_mismatch("value_id", want.value_id, got.value_id);
				if (got.sensor_value != want.sensor_value)
					note_mismatch("sensor_value", want.sensor_value, got.sensor_value);
				if (got.active_mask != want.active_mask)
					note_mismatch("active_mask", want.active_mask, got.active_mask);
				if (got.last != want.last)
					note_mismatch("last", want.last, got.last);
			end
		end
	end

	initial begin
		#1000000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		item.valid = 1'b0;
		item.opcode = OP_POLL;
		item.rx_byte = 8'h00;
		result.ready = 1'b0;
		active_bits = '0;
		poll_pending = 1'b0;
		polled_id = '0;
		scan_active = 1'b0;
		active_start = '0;
		inactive_start = '0;
		frame_count = '0;
		escape_pending = 1'b0;
		for (int i = 0; i < FRAME_BYTES; i++)
			frame_buf[i] = 8'h00;
		items_sent = 0;
		mismatch_count = 0;
		send_idle_pct = 21;
		recv_idle_pct = 52;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_idle_line();
		test_stuffed_frame();
		test_partial_and_bad_frame();
		test_mixed_traffic(150);
		send_idle_pct = 52;
		recv_idle_pct = 21;
		test_mixed_traffic(150);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_full_roster();

		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && tx_and_frame_due.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
`default_nettype wire
